// ----- hdl/bfasc_pkg.sv -----
package bfasc_pkg;

	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_SUB  = 2'd1;
	localparam logic [1:0] CMD_CMP  = 2'd2;
	localparam logic [1:0] CMD_RSVD = 2'd3;

	localparam logic [1:0] CMP_EQ = 2'd0;
	localparam logic [1:0] CMP_GT = 2'd1;
	localparam logic [1:0] CMP_LT = 2'd2;

	localparam logic [7:0]  NEG_LIMIT = 8'h30;
	localparam logic [11:0] SIGN_STEP = 12'h500;
	localparam logic [11:0] ZERO_EXP  = 12'h100;
	localparam logic [10:0] EXP_WRAP  = 11'd1000;

	typedef struct packed {
		logic       sub;
		logic       cin;
		logic [3:0] x;
		logic [3:0] y;
	} alu_in_t;

	typedef struct packed {
		logic [3:0] d;
		logic       cout;
	} alu_out_t;

	function automatic logic is_neg(input logic [11:0] e);
		is_neg = e[11:4] > NEG_LIMIT;
	endfunction

	function automatic logic [10:0] exp_value(input logic [11:0] e);
		exp_value = {7'd0, e[11:8]} * 11'd100 + {7'd0, e[7:4]} * 11'd10 + {7'd0, e[3:0]};
	endfunction

	function automatic logic [1:0] cmp_code(input logic [11:0] ae, input logic [11:0] be,
			input logic mant_gt, input logic mant_lt);
		logic       an;
		logic       bn;
		logic [1:0] pos;
		logic [1:0] neg;
		logic [10:0] ea;
		logic [10:0] eb;
		an = is_neg(ae);
		bn = is_neg(be);
		ea = exp_value(ae);
		eb = exp_value(be);
		pos = CMP_EQ;
		neg = CMP_EQ;
		if (ea > eb) begin
			pos = CMP_GT;
			neg = CMP_LT;
		end else if (ea < eb) begin
			pos = CMP_LT;
			neg = CMP_GT;
		end else if (mant_gt) begin
			pos = CMP_GT;
			neg = CMP_LT;
		end else if (mant_lt) begin
			pos = CMP_LT;
			neg = CMP_GT;
		end
		if (an != bn) begin
			cmp_code = an ? CMP_LT : CMP_GT;
		end else begin
			cmp_code = an ? neg : pos;
		end
	endfunction

endpackage

// ----- hdl/bcd_float_add_sub_compare_unit.sv -----
// sequence: an unknown command answers zeros straight from idle, compare goes through the compare state;
// add and subtract run the sign strip steps, then the align and digit loops (the digit loop on
// the single digit unit) and a carry step (add) or normalise loop (subtract), one digit per cycle
// throughput: one transaction at a time, the next is taken at the edge ending the result strobe
// the result is shown for one cycle on done; the receiver cannot stall
// reset: asynchronous active low, clears the sequencer and the strobe
module bcd_float_add_sub_compare_unit
	import bfasc_pkg::*;
#(
	parameter int MANT_DIGITS = 15
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               cmd,
	input  logic [11:0]              a_exp,
	input  logic [4*MANT_DIGITS-1:0] a_mantissa,
	input  logic [11:0]              b_exp,
	input  logic [4*MANT_DIGITS-1:0] b_mantissa,
	output logic                     done,
	output logic [11:0]              res_exp,
	output logic [4*MANT_DIGITS-1:0] res_mantissa,
	output logic [1:0]               cmp_result
);

	localparam int MW = 4 * MANT_DIGITS;
	localparam int CW = $clog2(MANT_DIGITS + 1);
	localparam logic [CW-1:0] N_DIG = CW'(MANT_DIGITS);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RES   = 4'd1;
	localparam logic [3:0] S_CMPS  = 4'd2;
	localparam logic [3:0] S_SETUP = 4'd3;
	localparam logic [3:0] S_ALIGN = 4'd4;
	localparam logic [3:0] S_ARITH = 4'd5;
	localparam logic [3:0] S_CARRY = 4'd6;
	localparam logic [3:0] S_NORM  = 4'd7;
	localparam logic [3:0] S_E1    = 4'd8;
	localparam logic [3:0] S_E2    = 4'd9;
	localparam logic [3:0] S_E3    = 4'd10;
	localparam logic [3:0] S_CMPC  = 4'd11;

	logic [3:0]    state_q;
	logic          sub_q;
	logic [11:0]   a_exp_q;
	logic [11:0]   b_exp_q;
	logic [MW-1:0] a_man_q;
	logic [MW-1:0] b_man_q;
	logic [11:0]   off_q;
	logic [MW-1:0] x_q;
	logic [MW-1:0] y_q;
	logic [MW-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic          carry_q;
	logic [10:0]   ev_q;
	logic [4:0]    hund_q;
	logic [6:0]    rem_q;
	logic          done_q;
	logic [11:0]   res_exp_q;
	logic [MW-1:0] res_man_q;
	logic [1:0]    cmp_q;

	logic          an;
	logic          bn;
	logic [10:0]   ea;
	logic [10:0]   eb;
	logic [1:0]    cmp_now;
	logic [10:0]   exp_gap;
	alu_in_t       alu_op;
	alu_out_t      alu_res;
	logic [21:0]   recip;
	logic [10:0]   hund_x;
	logic [14:0]   tens_p;
	logic [3:0]    tens;
	logic [6:0]    units;

	assign an      = is_neg(a_exp_q);
	assign bn      = is_neg(b_exp_q);
	assign ea      = exp_value(a_exp_q);
	assign eb      = exp_value(b_exp_q);
	assign cmp_now = cmp_code(a_exp_q, b_exp_q, a_man_q > b_man_q, a_man_q < b_man_q);
	assign exp_gap = (sub_q || ea > eb) ? (ea - eb) : (eb - ea);

	assign alu_op.sub = sub_q;
	assign alu_op.cin = carry_q;
	assign alu_op.x   = x_q[3:0];
	assign alu_op.y   = y_q[3:0];

	bfasc_digit_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	assign recip  = {11'd0, ev_q} * 22'd1311;
	assign hund_x = {6'd0, hund_q} * 11'd100;
	assign tens_p = {8'd0, rem_q} * 15'd205;
	assign tens   = tens_p[14:11];
	assign units  = rem_q - {3'd0, tens} * 7'd10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						a_exp_q <= a_exp;
						b_exp_q <= b_exp;
						a_man_q <= a_mantissa;
						b_man_q <= b_mantissa;
						sub_q   <= cmd == CMD_SUB;
						off_q   <= '0;
						if (cmd == CMD_ADD || cmd == CMD_SUB) begin
							state_q <= S_RES;
						end else if (cmd == CMD_CMP) begin
							state_q <= S_CMPC;
						end else begin
							res_exp_q <= '0;
							res_man_q <= '0;
							cmp_q     <= CMP_EQ;
							done_q    <= 1'b1;
						end
					end
				end
				S_CMPC: begin
					res_exp_q <= '0;
					res_man_q <= '0;
					cmp_q     <= cmp_now;
					done_q    <= 1'b1;
					state_q   <= S_IDLE;
				end
				S_RES: begin
					if (!sub_q) begin
						if (an && bn) begin
							a_exp_q <= a_exp_q - SIGN_STEP;
							b_exp_q <= b_exp_q - SIGN_STEP;
							off_q   <= off_q + SIGN_STEP;
						end else if (an) begin
							a_exp_q <= b_exp_q;
							a_man_q <= b_man_q;
							b_exp_q <= a_exp_q - SIGN_STEP;
							b_man_q <= a_man_q;
							sub_q   <= 1'b1;
						end else if (bn) begin
							b_exp_q <= b_exp_q - SIGN_STEP;
							sub_q   <= 1'b1;
						end else begin
							state_q <= S_SETUP;
						end
					end else begin
						if (an && bn) begin
							a_exp_q <= b_exp_q - SIGN_STEP;
							a_man_q <= b_man_q;
							b_exp_q <= a_exp_q - SIGN_STEP;
							b_man_q <= a_man_q;
						end else if (bn) begin
							b_exp_q <= b_exp_q - SIGN_STEP;
							sub_q   <= 1'b0;
						end else if (an) begin
							a_exp_q <= a_exp_q - SIGN_STEP;
							sub_q   <= 1'b0;
							off_q   <= off_q + SIGN_STEP;
						end else begin
							state_q <= S_CMPS;
						end
					end
				end
				S_CMPS: begin
					if (cmp_now == CMP_LT) begin
						a_exp_q <= b_exp_q;
						a_man_q <= b_man_q;
						b_exp_q <= a_exp_q;
						b_man_q <= a_man_q;
						off_q   <= off_q + SIGN_STEP;
					end else if (cmp_now == CMP_EQ) begin
						res_exp_q <= ZERO_EXP + off_q;
						res_man_q <= '0;
						cmp_q     <= CMP_EQ;
						done_q    <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					if (sub_q || ea > eb) begin
						x_q  <= a_man_q;
						y_q  <= b_man_q;
						ev_q <= ea;
					end else begin
						x_q  <= b_man_q;
						y_q  <= a_man_q;
						ev_q <= eb;
					end
					cnt_q   <= (exp_gap > 11'(MANT_DIGITS)) ? N_DIG : exp_gap[CW-1:0];
					state_q <= S_ALIGN;
				end
				S_ALIGN: begin
					if (cnt_q != '0) begin
						y_q   <= y_q >> 4;
						cnt_q <= cnt_q - CW'(1);
					end else begin
						cnt_q   <= N_DIG;
						carry_q <= 1'b0;
						state_q <= S_ARITH;
					end
				end
				S_ARITH: begin
					acc_q   <= {alu_res.d, acc_q[MW-1:4]};
					x_q     <= x_q >> 4;
					y_q     <= y_q >> 4;
					carry_q <= alu_res.cout;
					cnt_q   <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= sub_q ? S_NORM : S_CARRY;
					end
				end
				S_CARRY: begin
					if (carry_q) begin
						acc_q <= {4'd1, acc_q[MW-1:4]};
						ev_q  <= ev_q + 11'd1;
					end
					state_q <= S_E1;
				end
				S_NORM: begin
					if (cnt_q < N_DIG && acc_q[MW-1:MW-4] == 4'd0) begin
						acc_q <= acc_q << 4;
						cnt_q <= cnt_q + CW'(1);
					end else begin
						if (ev_q < 11'(cnt_q)) begin
							ev_q <= ev_q + EXP_WRAP - 11'(cnt_q);
						end else begin
							ev_q <= ev_q - 11'(cnt_q);
						end
						state_q <= S_E1;
					end
				end
				S_E1: begin
					hund_q  <= recip[21:17];
					state_q <= S_E2;
				end
				S_E2: begin
					rem_q   <= 7'(ev_q - hund_x);
					state_q <= S_E3;
				end
				S_E3: begin
					res_exp_q <= {hund_q[3:0], tens, units[3:0]} + off_q;
					res_man_q <= acc_q;
					cmp_q     <= CMP_EQ;
					done_q    <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = state_q != S_IDLE;
	assign done         = done_q;
	assign res_exp      = res_exp_q;
	assign res_mantissa = res_man_q;
	assign cmp_result   = cmp_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == CMD_ADD || cmd == CMD_SUB || cmd == CMD_CMP)) |=> busy)
		else $error("accepted transaction did not raise busy");
	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cmp_result != CMP_EQ) |-> (res_exp == '0 && res_mantissa == '0))
		else $error("compare result carries a number");
`endif

endmodule

// ----- hdl/bfasc_digit_alu.sv -----
module bfasc_digit_alu
	import bfasc_pkg::*;
(
	input  alu_in_t  op,
	output alu_out_t res
);

	logic [5:0] sum;
	logic [5:0] dif;
	logic [5:0] dif_fix;

	assign sum     = {2'd0, op.x} + {2'd0, op.y} + {5'd0, op.cin};
	assign dif     = {2'd0, op.x} - {5'd0, op.cin} - {2'd0, op.y};
	assign dif_fix = dif + 6'd10;

	always_comb begin
		if (op.sub) begin
			res.cout = dif[5];
			res.d    = dif[5] ? dif_fix[3:0] : dif[3:0];
		end else begin
			res.cout = sum >= 6'd10;
			res.d    = (sum >= 6'd10) ? (sum[3:0] - 4'd10) : sum[3:0];
		end
	end

endmodule

// ----- bench/bfasc_checker.sv -----
module bfasc_checker
	import bfasc_pkg::*;
#(
	parameter int MANT_DIGITS = 15
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [1:0]               cmd,
	input  logic [11:0]              a_exp,
	input  logic [4*MANT_DIGITS-1:0] a_mantissa,
	input  logic [11:0]              b_exp,
	input  logic [4*MANT_DIGITS-1:0] b_mantissa,
	input  logic                     done,
	input  logic [11:0]              res_exp,
	input  logic [4*MANT_DIGITS-1:0] res_mantissa,
	input  logic [1:0]               cmp_result,
	output int                       fail_count,
	output int                       pending_count
);

	typedef logic [4*MANT_DIGITS-1:0] mant_t;

	typedef struct {
		logic [11:0] e;
		mant_t       m;
	} dec_t;

	typedef struct {
		logic [11:0] e;
		mant_t       m;
		logic [1:0]  c;
	} outcome_t;

	outcome_t awaited[$];

	function automatic logic negative(logic [11:0] e);
		return e[11:4] > 8'h30;
	endfunction

	function automatic logic [11:0] unsign_exp(logic [11:0] e);
		return e - 12'h500;
	endfunction

	function automatic logic [11:0] sign_exp(logic [11:0] e);
		return e + 12'h500;
	endfunction

	function automatic int exp_of(logic [11:0] e);
		return int'(e[11:8]) * 100 + int'(e[7:4]) * 10 + int'(e[3:0]);
	endfunction

	function automatic logic [11:0] exp_pack(int v);
		logic [11:0] r;
		if (v < 0)
			v += 1000;
		r[11:8] = 4'((v / 100) % 16);
		r[7:4] = 4'((v % 100) / 10);
		r[3:0] = 4'(v % 10);
		return r;
	endfunction

	function automatic int digit(mant_t m, int i);
		return int'(m[4*(MANT_DIGITS-1-i) +: 4]);
	endfunction

	// 1 a greater, 0 equal, -1 a less
	function automatic int order_of(dec_t a, dec_t b);
		logic an;
		logic bn;
		int s;
		int ea;
		int eb;
		an = negative(a.e);
		bn = negative(b.e);
		if (an != bn)
			return an ? -1 : 1;
		s = an ? -1 : 1;
		ea = exp_of(a.e);
		eb = exp_of(b.e);
		if (ea > eb)
			return s;
		if (ea < eb)
			return -s;
		for (int i = 0; i < MANT_DIGITS; i++) begin
			if (digit(a.m, i) > digit(b.m, i))
				return s;
			if (digit(a.m, i) < digit(b.m, i))
				return -s;
		end
		return 0;
	endfunction

	function automatic dec_t dec_sum(dec_t a, dec_t b);
		dec_t r;
		dec_t hi;
		dec_t lo;
		int ea;
		int eb;
		int sh;
		int be;
		int cy;
		int t;
		mant_t acc;
		if (negative(a.e) && negative(b.e)) begin
			a.e = unsign_exp(a.e);
			b.e = unsign_exp(b.e);
			r = dec_sum(a, b);
			r.e = sign_exp(r.e);
			return r;
		end
		if (negative(a.e)) begin
			a.e = unsign_exp(a.e);
			return dec_diff(b, a);
		end
		if (negative(b.e)) begin
			b.e = unsign_exp(b.e);
			return dec_diff(a, b);
		end
		ea = exp_of(a.e);
		eb = exp_of(b.e);
		if (ea > eb) begin
			hi = a; lo = b; sh = ea - eb; be = ea;
		end else begin
			hi = b; lo = a; sh = eb - ea; be = eb;
		end
		cy = 0;
		acc = '0;
		for (int i = MANT_DIGITS - 1; i >= 0; i--) begin
			t = digit(hi.m, i) + cy;
			if (i >= sh)
				t += digit(lo.m, i - sh);
			if (t >= 10) begin
				t -= 10; cy = 1;
			end else
				cy = 0;
			acc[4*(MANT_DIGITS-1-i) +: 4] = 4'(t);
		end
		if (cy != 0) begin
			be++;
			r.m = acc >> 4;
			r.m[4*MANT_DIGITS-1 -: 4] = 4'd1;
		end else
			r.m = acc;
		r.e = exp_pack(be);
		return r;
	endfunction

	function automatic dec_t dec_diff(dec_t a, dec_t b);
		dec_t r;
		int c;
		int ea;
		int sh;
		int bw;
		int t;
		int k;
		mant_t acc;
		if (negative(a.e) && negative(b.e)) begin
			a.e = unsign_exp(a.e);
			b.e = unsign_exp(b.e);
			return dec_diff(b, a);
		end
		if (negative(b.e)) begin
			b.e = unsign_exp(b.e);
			return dec_sum(a, b);
		end
		if (negative(a.e)) begin
			a.e = unsign_exp(a.e);
			r = dec_sum(a, b);
			r.e = sign_exp(r.e);
			return r;
		end
		c = order_of(a, b);
		if (c < 0) begin
			r = dec_diff(b, a);
			r.e = sign_exp(r.e);
			return r;
		end
		r.m = '0;
		if (c == 0) begin
			r.e = ZERO_EXP;
			return r;
		end
		ea = exp_of(a.e);
		sh = ea - exp_of(b.e);
		bw = 0;
		acc = '0;
		for (int i = MANT_DIGITS - 1; i >= 0; i--) begin
			t = digit(a.m, i) - bw;
			if (i >= sh)
				t -= digit(b.m, i - sh);
			if (t < 0) begin
				t += 10; bw = 1;
			end else
				bw = 0;
			acc[4*(MANT_DIGITS-1-i) +: 4] = 4'(t);
		end
		k = 0;
		while (k < MANT_DIGITS && digit(acc, k) == 0)
			k++;
		r.m = (k < MANT_DIGITS) ? acc << (4 * k) : '0;
		r.e = exp_pack(ea - k);
		return r;
	endfunction

	assign pending_count = awaited.size();

	always @(posedge clk or negedge arst_n) begin
		dec_t x;
		dec_t y;
		dec_t z;
		outcome_t o;
		int c;
		int errs;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			errs = 0;
			if (start && !busy) begin
				x.e = a_exp; x.m = a_mantissa;
				y.e = b_exp; y.m = b_mantissa;
				o = '{e: '0, m: '0, c: CMP_EQ};
				if (cmd == CMD_ADD || cmd == CMD_SUB) begin
					z = (cmd == CMD_ADD) ? dec_sum(x, y) : dec_diff(x, y);
					o.e = z.e;
					o.m = z.m;
				end else if (cmd == CMD_CMP) begin
					c = order_of(x, y);
					o.c = (c > 0) ? CMP_GT : ((c < 0) ? CMP_LT : CMP_EQ);
				end
				awaited.push_back(o);
			end
			if (done) begin
				if (awaited.size() == 0) begin
					$error("result with no transaction outstanding");
					errs++;
				end else begin
					o = awaited.pop_front();
					if (res_exp !== o.e) begin
						$error("res_exp expected %h actual %h", o.e, res_exp);
						errs++;
					end
					if (res_mantissa !== o.m) begin
						$error("res_mantissa expected %h actual %h", o.m, res_mantissa);
						errs++;
					end
					if (cmp_result !== o.c) begin
						$error("cmp_result expected %0d actual %0d", o.c, cmp_result);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end

endmodule

// ----- bench/tb.sv -----
module tb;
	import bfasc_pkg::*;

	localparam int MANT_DIGITS = 15;
	localparam int MW = 4 * MANT_DIGITS;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	logic [1:0]    cmd = CMD_ADD;
	logic [11:0]   a_exp = '0;
	logic [MW-1:0] a_mantissa = '0;
	logic [11:0]   b_exp = '0;
	logic [MW-1:0] b_mantissa = '0;
	logic          done;
	logic [11:0]   res_exp;
	logic [MW-1:0] res_mantissa;
	logic [1:0]    cmp_result;
	int            fail_count;
	int            pending_count;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	bcd_float_add_sub_compare_unit #(.MANT_DIGITS(MANT_DIGITS)) u_top (.*);

	bfasc_checker #(.MANT_DIGITS(MANT_DIGITS)) u_checker (.*);

	function automatic logic [11:0] any_exp();
		logic [11:0] e;
		case ($urandom_range(0, 9))
			0: e = 12'($urandom);
			1: e = 12'h300 | 12'($urandom_range(0, 15));
			2: e = 12'h800 | 12'($urandom_range(0, 255));
			default: begin
				e[11:8] = 4'($urandom_range(0, 9));
				e[7:4] = 4'($urandom_range(0, 9));
				e[3:0] = 4'($urandom_range(0, 9));
			end
		endcase
		return e;
	endfunction

	function automatic logic [MW-1:0] any_mant();
		logic [MW-1:0] m;
		for (int i = 0; i < MANT_DIGITS; i++)
			m[4*i +: 4] = ($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
		if ($urandom_range(0, 3) == 0)
			m = m >> (4 * $urandom_range(0, MANT_DIGITS));
		return m;
	endfunction

	// start stays high across a zero gap so it is never driven twice in one step
	task automatic issue(logic [1:0] c, logic [11:0] ae, logic [MW-1:0] am,
			logic [11:0] be, logic [MW-1:0] bm);
		int gap;
		start <= 1'b1;
		cmd <= c;
		a_exp <= ae;
		a_mantissa <= am;
		b_exp <= be;
		b_mantissa <= bm;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		gap = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 18)) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		logic [11:0]   e;
		logic [MW-1:0] m;
		logic [1:0]    c;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed corners
		issue(CMD_ADD, 12'h100, 60'h999999999999999, 12'h100, 60'h999999999999999);
		issue(CMD_ADD, 12'h105, 60'h500000000000000, 12'h100, 60'h500000000000000);
		issue(CMD_SUB, 12'h100, 60'h123456789012345, 12'h100, 60'h123456789012345);
		issue(CMD_SUB, 12'h100, 60'h100000000000000, 12'h099, 60'h999999999999999);
		issue(CMD_SUB, 12'h100, 60'h100000000000000, 12'h110, 60'h100000000000000);
		issue(CMD_SUB, 12'h600, 60'h200000000000000, 12'h100, 60'h200000000000000);
		issue(CMD_SUB, 12'h100, 60'h200000000000000, 12'h600, 60'h300000000000000);
		issue(CMD_ADD, 12'h600, 60'h200000000000000, 12'h600, 60'h300000000000000);
		issue(CMD_ADD, 12'h600, 60'h200000000000000, 12'h100, 60'h200000000000000);
		issue(CMD_SUB, 12'h600, 60'h100000000000000, 12'h600, 60'h100000000000000);
		issue(CMD_ADD, 12'hFFF, 60'hFFFFFFFFFFFFFFF, 12'hFFF, 60'hFFFFFFFFFFFFFFF);
		issue(CMD_SUB, 12'hB00, 60'h100000000000000, 12'h000, 60'h000000000000000);
		issue(CMD_ADD, 12'h000, 60'h0, 12'h000, 60'h0);
		issue(CMD_ADD, 12'h999, 60'h999999999999999, 12'h999, 60'h999999999999999);
		issue(CMD_CMP, 12'h30F, 60'h1, 12'h310, 60'h1);
		issue(CMD_CMP, 12'h600, 60'h1, 12'h100, 60'h1);
		issue(CMD_CMP, 12'h600, 60'h5, 12'h600, 60'h4);
		issue(CMD_CMP, 12'h123, 60'h777, 12'h123, 60'h777);
		issue(CMD_CMP, 12'h100, 60'h5, 12'h100, 60'h4);
		issue(CMD_RSVD, 12'hFFF, 60'hFFFFFFFFFFFFFFF, 12'hFFF, 60'hFFFFFFFFFFFFFFF);
		issue(CMD_ADD, 12'h100, 60'hA00000000000000, 12'h100, 60'h0F0000000000000);
		issue(CMD_SUB, 12'h100, 60'h000000000000001, 12'h085, 60'h900000000000000);
		for (int n = 0; n < 1650; n++) begin
			c = ($urandom_range(0, 29) == 0) ? CMD_RSVD : 2'($urandom_range(0, 2));
			e = any_exp();
			m = any_mant();
			case ($urandom_range(0, 5))
				0: issue(c, e, m, e, m);
				1: issue(c, e, m, e + 12'h500, m);
				2: issue(c, e, m, e + 12'($urandom_range(0, 3)), any_mant());
				default: issue(c, e, m, any_exp(), any_mant());
			endcase
		end
		start <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
